FILE: rtl/core/vic_pkg.sv
`timescale 1ns / 1ps
// Package for the vectored interrupt controller.
// Opcodes, register map, source codes and controller/datapath structs. No dependencies.
package vic_pkg;

  localparam int unsigned NUM_SOURCES_DEF = 32;
  localparam int unsigned NUM_LEVELS_DEF  = 16;
  localparam int unsigned STACK_DEPTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINES = 2'd2,
    OP_NOP   = 2'd3
  } vic_op_e;

  localparam logic [11:0] A_IRQ_STATUS = 12'h000;
  localparam logic [11:0] A_FIQ_STATUS = 12'h004;
  localparam logic [11:0] A_RAW        = 12'h008;
  localparam logic [11:0] A_SELECT     = 12'h00c;
  localparam logic [11:0] A_ENABLE     = 12'h010;
  localparam logic [11:0] A_EN_CLEAR   = 12'h014;
  localparam logic [11:0] A_SOFT       = 12'h018;
  localparam logic [11:0] A_SOFT_CLEAR = 12'h01c;
  localparam logic [11:0] A_PROTECT    = 12'h020;
  localparam logic [11:0] A_PRIO_MASK  = 12'h024;
  localparam logic [11:0] A_DAISY_LVL  = 12'h028;
  localparam logic [11:0] A_VECT_LO    = 12'h100;
  localparam logic [11:0] A_VECT_HI    = 12'h180;
  localparam logic [11:0] A_PRIO_LO    = 12'h200;
  localparam logic [11:0] A_PRIO_HI    = 12'h280;
  localparam logic [11:0] A_ACK        = 12'hf00;
  localparam logic [11:0] A_ID0        = 12'hfe0;
  localparam logic [11:0] A_ID1        = 12'hfe4;

  localparam logic [31:0] ID0_VALUE = 32'h0004_1192;
  localparam logic [31:0] ID1_VALUE = 32'hb105_f00d;

  localparam logic [5:0] SRC_DAISY = 6'd32;
  localparam logic [5:0] SRC_NONE  = 6'd33;
  localparam logic [4:0] LVL_NONE  = 5'd16;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_wait;
    logic pop_wait;
    logic scan;
    logic daisy;
    logic vec_pick;
    logic deliver;
  } vic_cmd_t;

  typedef struct packed {
    logic tbl_rd;
    logic pop;
    logic refresh;
    logic scan_done;
    logic out_free;
  } vic_sts_t;

endpackage

FILE: rtl/core/vic_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the interrupt controller.
// Depends on nothing.
interface vic_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] bus_address;
  logic [31:0] write_data;
  logic [31:0] raw_lines;
  logic        daisy_request;
  logic [31:0] daisy_vector;

  modport source (output valid, opcode, bus_address, write_data, raw_lines,
                  daisy_request, daisy_vector, input ready);
  modport sink   (input valid, opcode, bus_address, write_data, raw_lines,
                  daisy_request, daisy_vector, output ready);
endinterface

interface vic_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_line;
  logic        fiq_line;
  logic        daisy_ack;
  logic        daisy_fin;
  logic        stack_error;

  modport source (output valid, read_data, irq_line, fiq_line, daisy_ack, daisy_fin,
                  stack_error, input ready);
  modport sink   (input valid, read_data, irq_line, fiq_line, daisy_ack, daisy_fin,
                  stack_error, output ready);
endinterface

FILE: rtl/core/vic_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the interrupt controller: one transaction at a time.
// Depends on vic_pkg.
module vic_ctrl import vic_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  vic_sts_t sts_i,
  output vic_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_EXEC    = 8'b0000_0010,
    S_RDWAIT  = 8'b0000_0100,
    S_POPWAIT = 8'b0000_1000,
    S_SCAN    = 8'b0001_0000,
    S_DAISY   = 8'b0010_0000,
    S_VEC     = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        if (sts_i.tbl_rd)       state_d = S_RDWAIT;
        else if (sts_i.pop)     state_d = S_POPWAIT;
        else if (sts_i.refresh) state_d = S_SCAN;
        else                    state_d = S_DONE;
      end
      S_RDWAIT:  state_d = S_DONE;
      S_POPWAIT: state_d = S_SCAN;
      S_SCAN:    if (sts_i.scan_done) state_d = S_DAISY;
      S_DAISY:   state_d = S_VEC;
      S_VEC:     state_d = S_DONE;
      S_DONE:    if (sts_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec     = (state_q == S_EXEC);
  assign cmd_o.rd_wait  = (state_q == S_RDWAIT);
  assign cmd_o.pop_wait = (state_q == S_POPWAIT);
  assign cmd_o.scan     = (state_q == S_SCAN);
  assign cmd_o.daisy    = (state_q == S_DAISY);
  assign cmd_o.vec_pick = (state_q == S_VEC);
  assign cmd_o.deliver  = (state_q == S_DONE) && sts_i.out_free;

endmodule

FILE: rtl/core/vic_dp.sv
`timescale 1ns / 1ps
// Datapath of the interrupt controller: registers, vector/priority tables,
// nesting stack, priority scan and response register. Depends on vic_pkg.
module vic_dp import vic_pkg::*; #(
  parameter int unsigned NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int unsigned NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vic_cmd_t    cmd_i,
  output vic_sts_t    sts_o,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] bus_address_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] raw_lines_i,
  input  logic        daisy_request_i,
  input  logic [31:0] daisy_vector_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic [31:0] read_data_o,
  output logic        irq_line_o,
  output logic        fiq_line_o,
  output logic        daisy_ack_o,
  output logic        daisy_fin_o,
  output logic        stack_error_o
);

  localparam int unsigned SRC_W = $clog2(NUM_SOURCES);
  localparam int unsigned CNT_W = SRC_W + 1;
  localparam int unsigned STK_W = $clog2(STACK_DEPTH);
  localparam int unsigned TOP_W = STK_W + 1;
  localparam logic [31:0] SRC_MASK = 32'((64'd1 << NUM_SOURCES) - 64'd1);

  // item
  vic_op_e     op_q;
  logic [11:0] addr_q;
  logic [31:0] wdata_q;

  // registers
  logic [31:0] raw_q, en_q, sel_q, soft_q;
  logic        prot_q;
  logic [15:0] pmask_q;
  logic [3:0]  dl_q;
  logic        dreq_q;
  logic [31:0] dvec_q;
  logic [31:0] vlatch_q;
  logic        irq_q;
  logic [TOP_W-1:0] top_q;
  logic [4:0]  active_q;
  logic [5:0]  serviced_q;
  logic [5:0]  winner_q;
  logic [3:0]  wlvl_q;
  logic        ack_q, fin_q, err_q;
  logic [31:0] rdata_q;

  // scan
  logic [CNT_W-1:0] cnt_q;
  logic [4:0]  best_lvl_q;
  logic [5:0]  best_src_q;

  // tables and stack
  logic [3:0]  prio_mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] prio_vld_q;
  logic [3:0]  prio_rd_q;
  logic        prio_rv_q;
  logic [31:0] vec_mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] vec_vld_q;
  logic [31:0] vec_rd_q;
  logic        vec_rv_q;
  logic [9:0]  stk_mem [STACK_DEPTH];
  logic [9:0]  stk_rd_q;

  // response
  logic        ovalid_q;
  logic [31:0] ordata_q;
  logic        oirq_q, ofiq_q, oack_q, ofin_q, oerr_q;

  logic        aligned, in_vec, in_prio, idx_ok, is_rd, is_wr, is_ack, is_fin;
  logic [4:0]  idx5;
  logic [SRC_W-1:0] tbl_idx, prio_ra, vec_ra, scan_i;
  logic [TOP_W-1:0] pop_ra;
  logic [31:0] pending, irq_st, fiq_st, reg_rdata, vec_val;
  logic [3:0]  prio_lvl;
  logic        push_ok, full_err, cand, daisy_cand;

  assign aligned = (addr_q[1:0] == 2'b00);
  assign idx5    = addr_q[6:2];
  assign tbl_idx = idx5[SRC_W-1:0];
  assign in_vec  = (addr_q >= A_VECT_LO) && (addr_q < A_VECT_HI);
  assign in_prio = (addr_q >= A_PRIO_LO) && (addr_q < A_PRIO_HI);
  assign idx_ok  = ({1'b0, idx5} < 6'(NUM_SOURCES));
  assign is_rd   = (op_q == OP_READ) && aligned;
  assign is_wr   = (op_q == OP_WRITE) && aligned;
  assign is_ack  = is_rd && (addr_q == A_ACK);
  assign is_fin  = is_wr && (addr_q == A_ACK);

  assign pending = (raw_q | soft_q) & en_q & SRC_MASK;
  assign irq_st  = pending & ~sel_q;
  assign fiq_st  = pending & sel_q;

  assign push_ok  = is_ack && (winner_q != SRC_NONE) && (top_q < TOP_W'(STACK_DEPTH));
  assign full_err = is_ack && (winner_q != SRC_NONE) && (top_q >= TOP_W'(STACK_DEPTH));

  assign sts_o.tbl_rd    = is_rd && (in_vec || in_prio) && idx_ok;
  assign sts_o.pop       = is_fin && (top_q != '0);
  assign sts_o.refresh   = is_wr || is_ack || (op_q == OP_LINES);
  assign sts_o.scan_done = (cnt_q == CNT_W'(NUM_SOURCES));
  assign sts_o.out_free  = !ovalid_q || rsp_ready_i;

  always_comb begin
    case (addr_q)
      A_IRQ_STATUS: reg_rdata = irq_st;
      A_FIQ_STATUS: reg_rdata = fiq_st;
      A_RAW:        reg_rdata = raw_q;
      A_SELECT:     reg_rdata = sel_q;
      A_ENABLE:     reg_rdata = en_q;
      A_SOFT:       reg_rdata = soft_q;
      A_PROTECT:    reg_rdata = {31'b0, prot_q};
      A_PRIO_MASK:  reg_rdata = {16'b0, pmask_q};
      A_DAISY_LVL:  reg_rdata = {28'b0, dl_q};
      A_ACK:        reg_rdata = vlatch_q;
      A_ID0:        reg_rdata = ID0_VALUE;
      A_ID1:        reg_rdata = ID1_VALUE;
      default:      reg_rdata = 32'b0;
    endcase
  end

  assign prio_ra  = cmd_i.scan ? cnt_q[SRC_W-1:0] : tbl_idx;
  assign vec_ra   = cmd_i.daisy ? best_src_q[SRC_W-1:0] : tbl_idx;
  assign pop_ra   = top_q - TOP_W'(2);
  assign prio_lvl = prio_rv_q ? prio_rd_q : 4'hf;
  assign vec_val  = vec_rv_q ? vec_rd_q : 32'b0;
  assign scan_i   = SRC_W'(cnt_q - CNT_W'(1));

  assign cand = (cnt_q != '0) && irq_st[scan_i] && pmask_q[prio_lvl] &&
                ({1'b0, prio_lvl} < 5'(NUM_LEVELS)) && ({1'b0, prio_lvl} < best_lvl_q);
  assign daisy_cand = dreq_q && pmask_q[dl_q] && ({1'b0, dl_q} < 5'(NUM_LEVELS)) &&
                      ({1'b0, dl_q} < best_lvl_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q  <= bus_address_i;
      wdata_q <= write_data_i;
    end
    if (cmd_i.exec && is_wr && in_prio && idx_ok) prio_mem[tbl_idx] <= wdata_q[3:0];
    if (cmd_i.exec && is_wr && in_vec && idx_ok)  vec_mem[tbl_idx] <= wdata_q;
    if (cmd_i.exec && push_ok) stk_mem[top_q[STK_W-1:0]] <= {wlvl_q, winner_q};
    prio_rd_q <= prio_mem[prio_ra];
    prio_rv_q <= prio_vld_q[prio_ra];
    vec_rd_q  <= vec_mem[vec_ra];
    vec_rv_q  <= vec_vld_q[vec_ra];
    stk_rd_q  <= stk_mem[pop_ra[STK_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= OP_NOP;
      raw_q      <= '0;
      en_q       <= '0;
      sel_q      <= '0;
      soft_q     <= '0;
      prot_q     <= 1'b0;
      pmask_q    <= 16'hffff;
      dl_q       <= 4'hf;
      dreq_q     <= 1'b0;
      dvec_q     <= '0;
      vlatch_q   <= '0;
      irq_q      <= 1'b0;
      top_q      <= '0;
      active_q   <= LVL_NONE;
      serviced_q <= SRC_NONE;
      winner_q   <= SRC_NONE;
      wlvl_q     <= '0;
      ack_q      <= 1'b0;
      fin_q      <= 1'b0;
      err_q      <= 1'b0;
      rdata_q    <= '0;
      cnt_q      <= '0;
      best_lvl_q <= LVL_NONE;
      best_src_q <= SRC_NONE;
      prio_vld_q <= '0;
      vec_vld_q  <= '0;
      ovalid_q   <= 1'b0;
      ordata_q   <= '0;
      oirq_q     <= 1'b0;
      ofiq_q     <= 1'b0;
      oack_q     <= 1'b0;
      ofin_q     <= 1'b0;
      oerr_q     <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        op_q  <= vic_op_e'(opcode_i);
        ack_q <= 1'b0;
        fin_q <= 1'b0;
        err_q <= 1'b0;
        if (vic_op_e'(opcode_i) == OP_LINES) begin
          raw_q  <= raw_lines_i;
          dreq_q <= daisy_request_i;
          dvec_q <= daisy_vector_i;
        end
      end

      if (cmd_i.exec) begin
        rdata_q    <= is_rd ? reg_rdata : 32'b0;
        cnt_q      <= '0;
        best_lvl_q <= LVL_NONE;
        best_src_q <= SRC_NONE;
        if (is_wr) begin
          case (addr_q)
            A_SELECT:     sel_q   <= wdata_q;
            A_ENABLE:     en_q    <= en_q | wdata_q;
            A_EN_CLEAR:   en_q    <= en_q & ~wdata_q;
            A_SOFT:       soft_q  <= soft_q | wdata_q;
            A_SOFT_CLEAR: soft_q  <= soft_q & ~wdata_q;
            A_PROTECT:    prot_q  <= wdata_q[0];
            A_PRIO_MASK:  pmask_q <= wdata_q[15:0];
            A_DAISY_LVL:  dl_q    <= wdata_q[3:0];
            default: ;
          endcase
          if (in_prio && idx_ok) prio_vld_q[tbl_idx] <= 1'b1;
          if (in_vec && idx_ok)  vec_vld_q[tbl_idx]  <= 1'b1;
        end
        if (push_ok) begin
          top_q      <= top_q + TOP_W'(1);
          active_q   <= {1'b0, wlvl_q};
          serviced_q <= winner_q;
          ack_q      <= (winner_q == SRC_DAISY);
        end
        if (is_fin && (top_q != '0)) begin
          top_q <= top_q - TOP_W'(1);
          fin_q <= (serviced_q == SRC_DAISY);
        end
        err_q <= full_err || (is_fin && (top_q == '0));
      end

      if (cmd_i.rd_wait) rdata_q <= in_vec ? vec_val : {28'b0, prio_lvl};

      if (cmd_i.pop_wait) begin
        if (top_q == '0) begin
          active_q   <= LVL_NONE;
          serviced_q <= SRC_NONE;
        end else begin
          active_q   <= {1'b0, stk_rd_q[9:6]};
          serviced_q <= stk_rd_q[5:0];
        end
      end

      if (cmd_i.scan) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cand) begin
          best_lvl_q <= {1'b0, prio_lvl};
          best_src_q <= 6'(scan_i);
        end
      end

      if (cmd_i.daisy && daisy_cand) begin
        best_lvl_q <= {1'b0, dl_q};
        best_src_q <= SRC_DAISY;
      end

      if (cmd_i.vec_pick) begin
        if ((irq_st != '0) || dreq_q) begin
          winner_q <= best_src_q;
          wlvl_q   <= best_lvl_q[3:0];
          vlatch_q <= (best_src_q < SRC_DAISY) ? vec_val : dvec_q;
          irq_q    <= (best_src_q != SRC_NONE) && (best_lvl_q < active_q);
        end else begin
          winner_q <= SRC_NONE;
          irq_q    <= 1'b0;
        end
      end

      if (cmd_i.deliver) begin
        ovalid_q <= 1'b1;
        ordata_q <= rdata_q;
        oirq_q   <= irq_q;
        ofiq_q   <= (fiq_st != '0);
        oack_q   <= ack_q;
        ofin_q   <= fin_q;
        oerr_q   <= err_q;
      end else if (rsp_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o   = ovalid_q;
  assign read_data_o   = ordata_q;
  assign irq_line_o    = oirq_q;
  assign fiq_line_o    = ofiq_q;
  assign daisy_ack_o   = oack_q;
  assign daisy_fin_o   = ofin_q;
  assign stack_error_o = oerr_q;

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TOP_W'(STACK_DEPTH)) else $error("nesting stack pointer out of range");

  a_irq_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_q |-> (winner_q != SRC_NONE)) else $error("irq raised without a winner");

  a_ack_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oack_q) |-> (!oerr_q && !ofin_q)) else $error("ack pulse with error");

endmodule

FILE: rtl/core/vectored_interrupt_controller.sv
`timescale 1ns / 1ps
// Vectored interrupt controller, top level.
// Depends on vic_pkg, vic_if, vic_ctrl and vic_dp.
//
// Usage: each request transaction is a bus read, a bus write, a no-op or an
// update of the raw interrupt lines and daisy-chain input; each gives exactly
// one response transaction with read data, IRQ/FIQ levels and ack/fin/error
// pulses. One request is processed at a time.
// Plain register reads, unaligned accesses and no-ops go straight to the response;
// vector/priority table reads first wait for the table read. Aligned writes, line
// updates and acknowledges run the winner scan, one source per cycle over the
// priority table's read port, then a daisy-chain compare and a vector table read;
// a finish that pops the stack first reads the nesting stack. A new request is
// accepted once the response has been registered.
// The response sits in an output register, so a new request is taken while
// a result waits; if the receiver stalls, the next result is held until the
// output register is free.
// Reset (rst_ni low, asynchronous) clears the state, control and response registers
// to their defaults; the tables read as reset values through per-entry valid bits.
module vectored_interrupt_controller import vic_pkg::*; #(
  parameter int unsigned NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int unsigned NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  vic_req_if.sink   req_i,
  vic_rsp_if.source rsp_o
);

  vic_cmd_t cmd;
  vic_sts_t sts;

  vic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vic_dp #(
    .NUM_SOURCES (NUM_SOURCES),
    .NUM_LEVELS  (NUM_LEVELS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (req_i.opcode),
    .bus_address_i   (req_i.bus_address),
    .write_data_i    (req_i.write_data),
    .raw_lines_i     (req_i.raw_lines),
    .daisy_request_i (req_i.daisy_request),
    .daisy_vector_i  (req_i.daisy_vector),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .read_data_o     (rsp_o.read_data),
    .irq_line_o      (rsp_o.irq_line),
    .fiq_line_o      (rsp_o.fiq_line),
    .daisy_ack_o     (rsp_o.daisy_ack),
    .daisy_fin_o     (rsp_o.daisy_fin),
    .stack_error_o   (rsp_o.stack_error)
  );

endmodule
